[sv/spq_pkg.sv]
package spq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;

   typedef enum logic [1:0] {
      STATUS_ENQUEUED = 2'd0,
      STATUS_DEQUEUED = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_READ,
      ST_COMPARE,
      ST_PLACE,
      ST_FINISH
   } state_type;

   typedef enum logic {
      MODE_ENQUEUE = 1'b0,
      MODE_DEQUEUE = 1'b1
   } mode_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] prio;
   } entry_type;

endpackage

[sv/spq_if.sv]
interface spq_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [31:0] item_value;
   logic signed [31:0] item_priority;

   modport source (output valid, mode, item_value, item_priority, input ready);
   modport sink   (input valid, mode, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] out_value;

   modport source (output valid, status, out_value, input ready);
   modport sink   (input valid, status, out_value, output ready);
endinterface

[sv/spq_store.sv]
module spq_store #(
   parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  spq_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output spq_pkg::entry_type  rd_data
);
   import spq_pkg::*;

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sorted_priority_queue.sv]
// sorted priority queue of QUEUE_DEPTH entries
// req channel: mode 0 enqueues item_value at item_priority, mode 1 dequeues
// the head entry (smallest priority, arrival order among equal priorities)
// rsp channel: exactly one item per request, status and out_value
// entries live in a single-port-write, single-port-read memory used as a ring;
// an enqueue walks back from the tail with one shared signed comparator,
// moving one larger entry up per read/compare pair
// steps after acceptance: a dequeue runs start, read, compare and finish;
// an empty or full report and an enqueue into an empty queue run start
// and finish; other enqueues repeat read and compare while a larger
// priority is found, then finish, or place and finish when all are larger
// one request is worked on at a time; req ready is high only while idle
// the result waits in the rsp register while the receiver stalls, and the
// block stays in its finish step until that register is free
// synchronous reset empties the queue and drops any pending rsp item;
// the memory is not cleared, only occupied slots are ever read
module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input logic          clock,
   input logic          reset,
   spq_req_if.sink      req,
   spq_rsp_if.source    rsp
);
   import spq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   state_type          state_ff, state_in;
   logic               mode_ff, mode_in;
   logic signed [31:0] value_ff, value_in;
   logic signed [31:0] prio_ff, prio_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [IDX_W-1:0]   hole_ff, hole_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   status_type         res_status_ff, res_status_in;
   logic signed [31:0] res_value_ff, res_value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   entry_type          rd_data;

   logic               rsp_free;
   logic               is_full;
   logic               is_empty;
   logic               greater;
   logic [IDX_W-1:0]   hole_prev;
   logic [IDX_W-1:0]   head_next;
   logic [IDX_W-1:0]   tail_next;

   spq_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign is_full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign greater   = (rd_data.prio > prio_ff);
   assign hole_prev = (hole_ff == '0) ? IDX_W'(QUEUE_DEPTH - 1) : hole_ff - 1'b1;
   assign head_next = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (mode_ff == MODE_DEQUEUE) begin
               state_in = is_empty ? ST_FINISH : ST_READ;
            end else if (is_full || pos_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (mode_ff == MODE_DEQUEUE || !greater) begin
               state_in = ST_FINISH;
            end else if (pos_ff == CNT_W'(1)) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_PLACE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath control
   always_comb begin
      mode_in       = mode_ff;
      value_in      = value_ff;
      prio_in       = prio_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      hole_in       = hole_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      wr_en         = 1'b0;
      wr_addr       = hole_ff;
      wr_data       = '{value: value_ff, prio: prio_ff};
      rd_en         = 1'b0;
      rd_addr       = hole_prev;
      req.ready     = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               mode_in  = req.mode;
               value_in = req.item_value;
               prio_in  = req.item_priority;
               hole_in  = tail_ff;
               pos_in   = count_ff;
            end
         end
         ST_START: begin
            res_value_in = '0;
            if (mode_ff == MODE_DEQUEUE) begin
               res_status_in = STATUS_EMPTY;
            end else if (is_full) begin
               res_status_in = STATUS_FULL;
            end else if (pos_ff == '0) begin
               wr_en         = 1'b1;
               tail_in       = tail_next;
               count_in      = count_ff + 1'b1;
               res_status_in = STATUS_ENQUEUED;
            end
         end
         ST_READ: begin
            rd_en   = 1'b1;
            rd_addr = (mode_ff == MODE_DEQUEUE) ? head_ff : hole_prev;
         end
         ST_COMPARE: begin
            if (mode_ff == MODE_DEQUEUE) begin
               res_status_in = STATUS_DEQUEUED;
               res_value_in  = rd_data.value;
               head_in       = head_next;
               count_in      = count_ff - 1'b1;
            end else if (greater) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               hole_in = hole_prev;
               pos_in  = pos_ff - 1'b1;
            end else begin
               wr_en         = 1'b1;
               tail_in       = tail_next;
               count_in      = count_ff + 1'b1;
               res_status_in = STATUS_ENQUEUED;
            end
         end
         ST_PLACE: begin
            wr_en         = 1'b1;
            tail_in       = tail_next;
            count_in      = count_ff + 1'b1;
            res_status_in = STATUS_ENQUEUED;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      prio_ff       <= prio_in;
      hole_ff       <= hole_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.out_value = rsp_value_ff;

endmodule

[test/sorted_priority_queue_tb.sv]
module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
   localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;

   typedef struct {
      status_type         status;
      logic signed [31:0] value;
   } outcome_type;

   logic clock;
   logic reset;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   sorted_priority_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   entry_type   held_entries[$];
   outcome_type pending_outcomes[$];
   bit          req_idling;
   bit          rsp_idling;
   int          mismatch_count;
   int          request_count;
   int          status_seen[4];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver side, random stalls
   always @(posedge clock) begin
      rsp_ch.ready <= !(rsp_idling && $urandom_range(99) < 19);
   end

   function automatic outcome_type predict_outcome(mode_type m, logic signed [31:0] v,
                                                   logic signed [31:0] p);
      outcome_type o;
      entry_type   e;
      int          pos;
      o.value = '0;
      if (m == MODE_ENQUEUE) begin
         if (held_entries.size() >= QUEUE_DEPTH) begin
            o.status = STATUS_FULL;
         end else begin
            // behind every entry of lower or equal priority
            pos = 0;
            while (pos < held_entries.size() && held_entries[pos].prio <= p) pos++;
            e.value = v;
            e.prio  = p;
            held_entries.insert(pos, e);
            o.status = STATUS_ENQUEUED;
         end
      end else begin
         if (held_entries.size() == 0) begin
            o.status = STATUS_EMPTY;
         end else begin
            e = held_entries.pop_front();
            o.value  = e.value;
            o.status = STATUS_DEQUEUED;
         end
      end
      return o;
   endfunction

   task automatic send_request(input mode_type m, input logic signed [31:0] v,
                               input logic signed [31:0] p);
      while (req_idling && $urandom_range(99) < 19) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.mode          <= m;
      req_ch.item_value    <= v;
      req_ch.item_priority <= p;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_outcomes.push_back(predict_outcome(m, v, p));
      request_count++;
   endtask

   function automatic logic signed [31:0] pick_priority();
      case ($urandom_range(3))
         0: return $signed($urandom_range(8)) - 4;
         1: begin
            case ($urandom_range(3))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $signed($urandom());
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected item: status %0d value %0d", rsp_ch.status,
                        rsp_ch.out_value);
         end else begin
            outcome_type o;
            o = pending_outcomes.pop_front();
            status_seen[rsp_ch.status]++;
            if (rsp_ch.status !== o.status || rsp_ch.out_value !== o.value) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected status %0d value %0d, got status %0d value %0d",
                           o.status, o.value, rsp_ch.status, rsp_ch.out_value);
            end
         end
      end
   end

   task automatic test_directed();
      logic signed [31:0] extra_prios[6];
      extra_prios = '{-32'sd2, 32'sd2, 32'sd3, -32'sd3, 32'sd100, -32'sd100};
      send_request(MODE_DEQUEUE, $signed($urandom()), $signed($urandom()));
      send_request(MODE_ENQUEUE, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_request(MODE_ENQUEUE, 32'sh8000_0000, 32'sh8000_0000);
      send_request(MODE_ENQUEUE, 32'sd0, 32'sd0);
      send_request(MODE_ENQUEUE, -32'sd1, -32'sd1);
      // equal priorities leave in arrival order
      send_request(MODE_ENQUEUE, 32'sd1, 32'sd5);
      send_request(MODE_ENQUEUE, 32'sd2, 32'sd5);
      send_request(MODE_ENQUEUE, 32'sd3, 32'sd5);
      send_request(MODE_ENQUEUE, 32'sh5a5a_5a5a, 32'sd0);
      send_request(MODE_ENQUEUE, 32'sh2a5a_a5a5, 32'sh7fff_ffff);
      send_request(MODE_ENQUEUE, 32'sh0f0f_0f0f, 32'sh8000_0000);
      foreach (extra_prios[i]) send_request(MODE_ENQUEUE, $signed($urandom()), extra_prios[i]);
      // queue now full
      send_request(MODE_ENQUEUE, 32'sh1234_5678, 32'sd0);
      repeat (6) send_request(MODE_DEQUEUE, $signed($urandom()), $signed($urandom()));
   endtask

   task automatic test_random_mix(input int count);
      int dequeue_bias;
      dequeue_bias = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) dequeue_bias = $urandom_range(20, 80);
         if ($urandom_range(99) < dequeue_bias)
            send_request(MODE_DEQUEUE, $signed($urandom()), $signed($urandom()));
         else
            send_request(MODE_ENQUEUE, $signed($urandom()), pick_priority());
      end
   endtask

   task automatic test_fill_drain(input int rounds);
      for (int r = 0; r < rounds; r++) begin
         repeat (QUEUE_DEPTH + $urandom_range(3))
            send_request(MODE_ENQUEUE, $signed($urandom()), pick_priority());
         repeat (QUEUE_DEPTH + $urandom_range(3))
            send_request(MODE_DEQUEUE, $signed($urandom()), $signed($urandom()));
      end
   endtask

   task automatic test_back_to_back(input int count);
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      test_random_mix(count);
      req_idling = 1'b1;
      rsp_idling = 1'b1;
   endtask

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.mode          = MODE_ENQUEUE;
      req_ch.item_value    = '0;
      req_ch.item_priority = '0;
      rsp_ch.ready         = 1'b0;
      req_idling           = 1'b1;
      rsp_idling           = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_mix(700);
      test_fill_drain(8);
      test_back_to_back(320);

      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d requests sent across directed, mixed, fill-drain and back-to-back runs",
               request_count);
      $display("outcomes: %0d enqueued, %0d dequeued, %0d empty, %0d full; %0d mismatches",
               status_seen[STATUS_ENQUEUED], status_seen[STATUS_DEQUEUED],
               status_seen[STATUS_EMPTY], status_seen[STATUS_FULL], mismatch_count);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end

endmodule

[filelist.f]
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_store.sv
sv/sorted_priority_queue.sv
test/sorted_priority_queue_tb.sv
